/* rtl/adaptive_traffic_light_controller_defines.svh */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge
`define ATLC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("atlc check failed");

// consequent holds in the cycle after the antecedent
`define ATLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atlc check failed");

`else

`define ATLC_ASSERT_ALWAYS(label, cond)
`define ATLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/atlc_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller package
// Shared widths, codes, reset values and the lane state record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atlc_pkg;

    localparam int NUM_LANES   = 4;
    localparam int LANE_W      = 2;
    localparam int COUNT_W     = 8;
    localparam int TICKS_W     = 16;
    localparam int CYCLE_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [2:0] NO_LANE = 3'd4;

    localparam logic [TICKS_W-1:0] ALL_RED_RST   = 16'd2000;
    localparam logic [TICKS_W-1:0] GREEN_RST     = 16'd8000;
    localparam logic [TICKS_W-1:0] YELLOW_RST    = 16'd1000;
    localparam logic [TICKS_W-1:0] AMB_RED_RST   = 16'd3000;
    localparam logic [TICKS_W-1:0] AMB_GREEN_RST = 16'd10000;
    localparam logic [TICKS_W-1:0] BUS_HOLD_RST  = 16'd10000;
    localparam logic [COUNT_W-1:0] THRESHOLD_RST = 8'd3;
    localparam logic [CYCLE_W-1:0] ROUND_RST     = 3'd4;

    typedef enum logic [2:0] {
        PH_RED       = 3'd0,
        PH_GREEN     = 3'd1,
        PH_YELLOW    = 3'd2,
        PH_AMB_RED   = 3'd3,
        PH_AMB_GREEN = 3'd4,
        PH_AMB_YEL   = 3'd5,
        PH_BUS_HOLD  = 3'd6
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALL_RED   = 3'd0,
        CFG_GREEN     = 3'd1,
        CFG_YELLOW    = 3'd2,
        CFG_AMB_RED   = 3'd3,
        CFG_AMB_GREEN = 3'd4,
        CFG_BUS_HOLD  = 3'd5,
        CFG_THRESHOLD = 3'd6,
        CFG_ROUND     = 3'd7
    } cfg_index_t;

    typedef logic [NUM_LANES-1:0][COUNT_W-1:0] lane_counts_t;

    typedef struct packed {
        logic [LANE_W-1:0]  current_lane;
        logic [2:0]         return_lane;
        logic               jump_used;
        logic               skip_two;
        logic [CYCLE_W-1:0] cycle_count;
    } lane_state_t;

endpackage

/* rtl/atlc_intf.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller channels
// Valid/ready channels for tick words and light words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atlc_tick_if;
    logic                           valid;
    logic                           ready;
    logic [atlc_pkg::NUM_LANES-1:0] lane_sensors;
    logic                           ambulance_request;
    logic                           bus_request;

    modport source (output valid, output lane_sensors, output ambulance_request,
                    output bus_request, input ready);
    modport sink   (input valid, input lane_sensors, input ambulance_request,
                    input bus_request, output ready);
endinterface

interface atlc_light_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    signal_phase;
    logic [atlc_pkg::LANE_W-1:0]   lit_lane;
    logic                          bus_green;

    modport source (output valid, output signal_phase, output lit_lane,
                    output bus_green, input ready);
    modport sink   (input valid, input signal_phase, input lit_lane,
                    input bus_green, output ready);
endinterface

/* rtl/atlc_next_lane.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller next lane selection
// Return after a jump, priority jump, step and round reset at end of yellow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atlc_next_lane (
    input  atlc_pkg::lane_state_t                state_cur,
    input  atlc_pkg::lane_counts_t               counts,
    input  logic [atlc_pkg::COUNT_W-1:0]         threshold,
    input  logic [atlc_pkg::CYCLE_W-1:0]         cycles_per_round,
    output atlc_pkg::lane_state_t                state_new,
    output logic [atlc_pkg::NUM_LANES-1:0]       clear_count
);

    logic [2:0]                   cur;
    logic [2:0]                   ret_base;
    logic [atlc_pkg::CYCLE_W-1:0] cycle_inc;
    logic                         step;
    logic                         found;
    logic                         skip_new;
    logic                         jump_new;
    logic [2:0]                   return_new;

    always_comb
    begin
        cur         = {1'b0, state_cur.current_lane};
        ret_base    = {1'b0, state_cur.return_lane[1:0]};
        cycle_inc   = state_cur.cycle_count + 3'd1;
        step        = 1'b1;
        found       = 1'b0;
        skip_new    = state_cur.skip_two;
        jump_new    = state_cur.jump_used;
        return_new  = state_cur.return_lane;
        clear_count = '0;

        if (state_cur.return_lane != atlc_pkg::NO_LANE)
        begin
            cur        = (cur == ret_base + 3'd1) ? ret_base + 3'd2 : ret_base + 3'd1;
            return_new = atlc_pkg::NO_LANE;
            step       = 1'b0;
        end

        for (int i = 0; i < atlc_pkg::NUM_LANES; i++)
        begin
            if (!found && !state_cur.jump_used && counts[i] >= threshold &&
                ({1'b0, 3'(i)} > ({1'b0, cur} + 4'd1)))
            begin
                found          = 1'b1;
                if (i == 2)
                begin
                    skip_new = 1'b1;
                end
                clear_count[i] = 1'b1;
                return_new     = {1'b0, cur[1:0]};
                cur            = 3'(i);
                jump_new       = 1'b1;
                step           = 1'b0;
            end
        end

        if (step && skip_new)
        begin
            cur      = cur + 3'd2;
            skip_new = 1'b0;
        end
        else if (step)
        begin
            cur = cur + 3'd1;
        end

        if (cur > 3'd3)
        begin
            cur = 3'd0;
        end

        state_new.cycle_count = cycle_inc;
        if (cycle_inc == cycles_per_round)
        begin
            jump_new              = 1'b0;
            cur                   = 3'd0;
            state_new.cycle_count = '0;
        end

        state_new.current_lane = cur[1:0];
        state_new.return_lane  = return_new;
        state_new.jump_used    = jump_new;
        state_new.skip_two     = skip_new;
    end

endmodule

/* rtl/adaptive_traffic_light_controller.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller
// Four-lane signal sequencer with sensor counting, ambulance and bus handling
// ----------------------------------------------------------------------------
//  channel    dir  word
//  tick_in    in   lane_sensors, ambulance_request, bus_request
//  light_out  out  signal_phase, lit_lane, bus_green
//  cfg        in   cfg_we, cfg_index, cfg_data (write only)
//
//  one tick word is taken per clock while tick_in is ready; its light word
//  appears in the cycle after and waits in an output register; tick_in is ready
//  while that register is empty or being taken in the same cycle
//  reset leaves the default timings, lane 0 in all-red, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_traffic_light_controller_defines.svh"

module adaptive_traffic_light_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    atlc_tick_if.sink                         tick_in,
    atlc_light_if.source                      light_out,
    input  logic                              cfg_we,
    input  logic [atlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [atlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [atlc_pkg::TICKS_W-1:0] all_red_reg;
    logic [atlc_pkg::TICKS_W-1:0] green_reg;
    logic [atlc_pkg::TICKS_W-1:0] yellow_reg;
    logic [atlc_pkg::TICKS_W-1:0] amb_red_reg;
    logic [atlc_pkg::TICKS_W-1:0] amb_green_reg;
    logic [atlc_pkg::TICKS_W-1:0] bus_hold_reg;
    logic [atlc_pkg::COUNT_W-1:0] threshold_reg;
    logic [atlc_pkg::CYCLE_W-1:0] round_reg;

    atlc_pkg::phase_t             phase_reg,   phase_next;
    logic [atlc_pkg::TICKS_W-1:0] timer_reg,   timer_next;
    atlc_pkg::lane_state_t        lane_reg,    lane_next;
    atlc_pkg::lane_counts_t       counts_reg,  counts_next;
    logic [atlc_pkg::NUM_LANES-1:0] seen_reg;
    logic                         amb_reg,     amb_next;

    logic                         out_valid_reg;
    logic [2:0]                   out_phase_reg;
    logic [atlc_pkg::LANE_W-1:0]  out_lane_reg;
    logic                         out_bus_reg;

    logic                           in_fire;
    atlc_pkg::lane_counts_t         counts_inc;
    logic                           amb_seen;
    logic [atlc_pkg::TICKS_W-1:0]   phase_len;
    logic                           phase_more;
    atlc_pkg::lane_state_t          chosen;
    logic [atlc_pkg::NUM_LANES-1:0] clear_count;
    logic [atlc_pkg::LANE_W-1:0]    lane_shown;
    logic                           amb_phase;

    assign tick_in.ready     = !out_valid_reg || light_out.ready;
    assign in_fire           = tick_in.valid && tick_in.ready;

    assign light_out.valid        = out_valid_reg;
    assign light_out.signal_phase = out_phase_reg;
    assign light_out.lit_lane     = out_lane_reg;
    assign light_out.bus_green    = out_bus_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_red_reg   <= atlc_pkg::ALL_RED_RST;
            green_reg     <= atlc_pkg::GREEN_RST;
            yellow_reg    <= atlc_pkg::YELLOW_RST;
            amb_red_reg   <= atlc_pkg::AMB_RED_RST;
            amb_green_reg <= atlc_pkg::AMB_GREEN_RST;
            bus_hold_reg  <= atlc_pkg::BUS_HOLD_RST;
            threshold_reg <= atlc_pkg::THRESHOLD_RST;
            round_reg     <= atlc_pkg::ROUND_RST;
        end
        else if (cfg_we)
        begin
            case (atlc_pkg::cfg_index_t'(cfg_index))
                atlc_pkg::CFG_ALL_RED:   all_red_reg   <= cfg_data;
                atlc_pkg::CFG_GREEN:     green_reg     <= cfg_data;
                atlc_pkg::CFG_YELLOW:    yellow_reg    <= cfg_data;
                atlc_pkg::CFG_AMB_RED:   amb_red_reg   <= cfg_data;
                atlc_pkg::CFG_AMB_GREEN: amb_green_reg <= cfg_data;
                atlc_pkg::CFG_BUS_HOLD:  bus_hold_reg  <= cfg_data;
                atlc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[atlc_pkg::COUNT_W-1:0];
                atlc_pkg::CFG_ROUND:     round_reg     <= cfg_data[atlc_pkg::CYCLE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // sensor edge counting
    always_comb
    begin
        for (int k = 0; k < atlc_pkg::NUM_LANES; k++)
        begin
            counts_inc[k] = counts_reg[k] +
                {{(atlc_pkg::COUNT_W-1){1'b0}}, tick_in.lane_sensors[k] & ~seen_reg[k]};
        end
        amb_seen = amb_reg | tick_in.ambulance_request;
    end

    always_comb
    begin
        case (phase_reg)
            atlc_pkg::PH_RED:       phase_len = all_red_reg;
            atlc_pkg::PH_GREEN:     phase_len = green_reg;
            atlc_pkg::PH_YELLOW:    phase_len = yellow_reg;
            atlc_pkg::PH_AMB_RED:   phase_len = amb_red_reg;
            atlc_pkg::PH_AMB_GREEN: phase_len = amb_green_reg;
            atlc_pkg::PH_AMB_YEL:   phase_len = yellow_reg;
            atlc_pkg::PH_BUS_HOLD:  phase_len = bus_hold_reg;
            default:                phase_len = 16'd1;
        endcase
    end

    assign phase_more = ({1'b0, timer_reg} + 17'd1) < {1'b0, phase_len};

    assign lane_shown = (phase_reg inside {atlc_pkg::PH_GREEN, atlc_pkg::PH_YELLOW}) ?
                        lane_reg.current_lane : '0;

    assign amb_phase = phase_reg inside {atlc_pkg::PH_AMB_RED, atlc_pkg::PH_AMB_GREEN,
                                         atlc_pkg::PH_AMB_YEL};

    atlc_next_lane u_next_lane (
        .state_cur        (lane_reg),
        .counts           (counts_inc),
        .threshold        (threshold_reg),
        .cycles_per_round (round_reg),
        .state_new        (chosen),
        .clear_count      (clear_count)
    );

    // phase sequencing
    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = '0;
        lane_next   = lane_reg;
        counts_next = counts_inc;
        amb_next    = amb_seen;

        if (phase_more)
        begin
            timer_next = timer_reg + 16'd1;
        end
        else
        begin
            case (phase_reg)
                atlc_pkg::PH_RED:       phase_next = atlc_pkg::PH_GREEN;
                atlc_pkg::PH_GREEN:     phase_next = atlc_pkg::PH_YELLOW;
                atlc_pkg::PH_YELLOW:
                begin
                    lane_next = chosen;
                    for (int k = 0; k < atlc_pkg::NUM_LANES; k++)
                    begin
                        if (clear_count[k])
                        begin
                            counts_next[k] = '0;
                        end
                    end
                    if (amb_seen)
                    begin
                        phase_next = atlc_pkg::PH_AMB_RED;
                    end
                    else
                    begin
                        phase_next = tick_in.bus_request ? atlc_pkg::PH_BUS_HOLD
                                                         : atlc_pkg::PH_RED;
                    end
                end
                atlc_pkg::PH_AMB_RED:   phase_next = atlc_pkg::PH_AMB_GREEN;
                atlc_pkg::PH_AMB_GREEN: phase_next = atlc_pkg::PH_AMB_YEL;
                atlc_pkg::PH_AMB_YEL:
                begin
                    amb_next   = 1'b0;
                    phase_next = tick_in.bus_request ? atlc_pkg::PH_BUS_HOLD
                                                     : atlc_pkg::PH_RED;
                end
                default:                phase_next = atlc_pkg::PH_RED;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= atlc_pkg::PH_RED;
            timer_reg     <= '0;
            lane_reg      <= '{current_lane: '0, return_lane: atlc_pkg::NO_LANE,
                               jump_used: 1'b0, skip_two: 1'b0, cycle_count: '0};
            counts_reg    <= '0;
            seen_reg      <= '0;
            amb_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                lane_reg   <= lane_next;
                counts_reg <= counts_next;
                seen_reg   <= tick_in.lane_sensors;
                amb_reg    <= amb_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (light_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // light word register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_phase_reg <= phase_reg;
            out_lane_reg  <= lane_shown;
            out_bus_reg   <= (phase_reg == atlc_pkg::PH_BUS_HOLD);
        end
    end

    `ATLC_ASSERT_NEXT(a_word_after_tick, in_fire, out_valid_reg)
    `ATLC_ASSERT_NEXT(a_phase_holds_idle, !in_fire, $stable(phase_reg))
    `ATLC_ASSERT_ALWAYS(a_amb_latched, !amb_phase || amb_reg)

endmodule

/* tb/adaptive_traffic_light_controller_checker.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller checker
// Watches the tick, light and register channels, keeps its own copy of the
// controller state, predicts one light word per tick word and compares it
// field by field with the light words in the order they leave the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_traffic_light_controller_checker
    import atlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    atlc_tick_if                   tick,
    atlc_light_if                  light,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     words_due
);

    typedef struct packed {
        phase_t            phase;
        logic [LANE_W-1:0] lane;
        logic              bus_green;
    } light_word_t;

    logic [TICKS_W-1:0] len_all_red;
    logic [TICKS_W-1:0] len_green;
    logic [TICKS_W-1:0] len_yellow;
    logic [TICKS_W-1:0] len_amb_red;
    logic [TICKS_W-1:0] len_amb_green;
    logic [TICKS_W-1:0] len_bus_hold;
    logic [COUNT_W-1:0] threshold;
    logic [CYCLE_W-1:0] round_len;

    phase_t               phase;
    logic [TICKS_W-1:0]   phase_timer;
    logic [LANE_W-1:0]    cur_lane;
    logic [2:0]           ret_lane;
    logic                 jump_used;
    logic                 skip_two;
    logic [CYCLE_W-1:0]   cycle_cnt;
    logic [COUNT_W-1:0]   vehicles [NUM_LANES];
    logic [NUM_LANES-1:0] sensor_seen;
    logic                 amb_pending;

    light_word_t light_words_due [$];
    light_word_t due_word;
    int          errors;

    task automatic reset_controller();
        len_all_red   = ALL_RED_RST;
        len_green     = GREEN_RST;
        len_yellow    = YELLOW_RST;
        len_amb_red   = AMB_RED_RST;
        len_amb_green = AMB_GREEN_RST;
        len_bus_hold  = BUS_HOLD_RST;
        threshold     = THRESHOLD_RST;
        round_len     = ROUND_RST;
        phase         = PH_RED;
        phase_timer   = '0;
        cur_lane      = '0;
        ret_lane      = NO_LANE;
        jump_used     = 1'b0;
        skip_two      = 1'b0;
        cycle_cnt     = '0;
        sensor_seen   = '0;
        amb_pending   = 1'b0;
        for (int k = 0; k < NUM_LANES; k++)
            vehicles[k] = '0;
    endtask

    function automatic logic [TICKS_W-1:0] phase_ticks(input phase_t p);
        case (p)
            PH_RED:       return len_all_red;
            PH_GREEN:     return len_green;
            PH_YELLOW:    return len_yellow;
            PH_AMB_RED:   return len_amb_red;
            PH_AMB_GREEN: return len_amb_green;
            PH_AMB_YEL:   return len_yellow;
            PH_BUS_HOLD:  return len_bus_hold;
            default:      return 16'd1;
        endcase
    endfunction

    // at the end of yellow: return after a jump, let a busy lane jump or move on, and reset the round
    task automatic pick_next_lane();
        int unsigned lane;
        int unsigned saved;
        logic        advance;
        lane      = cur_lane;
        advance   = 1'b1;
        cycle_cnt = cycle_cnt + 1'b1;
        if (ret_lane != NO_LANE) begin
            saved    = ret_lane[1:0];
            lane     = (lane == saved + 1) ? saved + 2 : saved + 1;
            ret_lane = NO_LANE;
            advance  = 1'b0;
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            if (!jump_used && vehicles[i] >= threshold && i > lane + 1) begin
                if (i == 2)
                    skip_two = 1'b1;
                vehicles[i] = '0;
                ret_lane    = 3'(lane & 3);
                lane        = i;
                jump_used   = 1'b1;
                advance     = 1'b0;
            end
        end
        if (advance && skip_two) begin
            lane     = lane + 2;
            skip_two = 1'b0;
        end
        else if (advance) begin
            lane = lane + 1;
        end
        if (lane > 3)
            lane = 0;
        if (cycle_cnt == round_len) begin
            jump_used = 1'b0;
            lane      = 0;
            cycle_cnt = '0;
        end
        cur_lane = LANE_W'(lane);
    endtask

    task automatic step_controller(input logic [NUM_LANES-1:0] sensors, input logic amb,
                                   input logic bus, output light_word_t light_word);
        for (int k = 0; k < NUM_LANES; k++) begin
            if (sensors[k] && !sensor_seen[k]) begin
                vehicles[k]    = vehicles[k] + 1'b1;
                sensor_seen[k] = 1'b1;
            end
            else if (!sensors[k] && sensor_seen[k]) begin
                sensor_seen[k] = 1'b0;
            end
        end
        if (amb)
            amb_pending = 1'b1;

        light_word.phase     = phase;
        light_word.lane      = (phase == PH_GREEN || phase == PH_YELLOW) ? cur_lane : '0;
        light_word.bus_green = (phase == PH_BUS_HOLD);

        if ({1'b0, phase_timer} + 17'd1 < {1'b0, phase_ticks(phase)}) begin
            phase_timer = phase_timer + 1'b1;
        end
        else begin
            phase_timer = '0;
            case (phase)
                PH_RED:       phase = PH_GREEN;
                PH_GREEN:     phase = PH_YELLOW;
                PH_YELLOW:
                begin
                    pick_next_lane();
                    if (amb_pending)
                        phase = PH_AMB_RED;
                    else
                        phase = bus ? PH_BUS_HOLD : PH_RED;
                end
                PH_AMB_RED:   phase = PH_AMB_GREEN;
                PH_AMB_GREEN: phase = PH_AMB_YEL;
                PH_AMB_YEL:
                begin
                    amb_pending = 1'b0;
                    phase       = bus ? PH_BUS_HOLD : PH_RED;
                end
                default:      phase = PH_RED;
            endcase
        end
    endtask

    task automatic report(input string field, input int want, input int got);
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_controller();
            light_words_due.delete();
            errors = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ALL_RED:   len_all_red   = cfg_data;
                    CFG_GREEN:     len_green     = cfg_data;
                    CFG_YELLOW:    len_yellow    = cfg_data;
                    CFG_AMB_RED:   len_amb_red   = cfg_data;
                    CFG_AMB_GREEN: len_amb_green = cfg_data;
                    CFG_BUS_HOLD:  len_bus_hold  = cfg_data;
                    CFG_THRESHOLD: threshold     = cfg_data[COUNT_W-1:0];
                    CFG_ROUND:     round_len     = cfg_data[CYCLE_W-1:0];
                    default:       ;
                endcase
            end
            if (tick.valid && tick.ready) begin
                step_controller(tick.lane_sensors, tick.ambulance_request, tick.bus_request,
                                due_word);
                light_words_due.push_back(due_word);
            end
            if (light.valid && light.ready) begin
                if (light_words_due.size() == 0) begin
                    $error("light word with no tick word waiting: phase %0d lane %0d",
                           light.signal_phase, light.lit_lane);
                    errors++;
                end
                else begin
                    due_word = light_words_due.pop_front();
                    if (light.signal_phase !== due_word.phase)
                        report("signal_phase", due_word.phase, light.signal_phase);
                    if (light.lit_lane !== due_word.lane)
                        report("lit_lane", due_word.lane, light.lit_lane);
                    if (light.bus_green !== due_word.bus_green)
                        report("bus_green", due_word.bus_green, light.bus_green);
                end
            end
        end
        fail_count <= errors;
        words_due  <= light_words_due.size();
    end

endmodule

/* tb/adaptive_traffic_light_controller_test.sv */
// ----------------------------------------------------------------------------
// Adaptive traffic light controller testbench
// Drives tick words and register writes, idles and stalls both channels at
// random, and gives the verdict from the failure count of the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_traffic_light_controller_test;
    import atlc_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int SEGMENTS         = 8;
    localparam int SEGMENT_WORDS    = 190;
    localparam int EXTREME_WORDS    = 40;
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 5;
    localparam int WATCHDOG_LIMIT   = 2000;

    // {lane_sensors, ambulance_request, bus_request}
    localparam logic [5:0] DIRECTED_TICKS [24] = '{
        6'b0000_0_0, 6'b1111_0_0, 6'b0000_0_1, 6'b1111_0_1,
        6'b0000_1_0, 6'b1111_1_1, 6'b0000_1_0, 6'b1111_0_1,
        6'b0000_0_0, 6'b1111_0_1, 6'b0101_0_0, 6'b1010_0_1,
        6'b0101_0_0, 6'b1010_1_0, 6'b0011_0_1, 6'b1100_0_0,
        6'b0011_0_1, 6'b1100_0_1, 6'b0000_1_1, 6'b1111_0_0,
        6'b0000_0_1, 6'b1111_0_0, 6'b0001_0_1, 6'b1000_0_1
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int   fail_count;
    int   words_due;
    int   stuck_cycles = 0;
    logic source_idling = 1'b0;
    logic sink_idling = 1'b0;
    logic sink_hold_req = 1'b0;

    atlc_tick_if  tick_if ();
    atlc_light_if light_if ();

    adaptive_traffic_light_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_in   (tick_if),
        .light_out (light_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adaptive_traffic_light_controller_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_if),
        .light      (light_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int idle_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_ticks();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 16'd1;
            2:       return CFG_DATA_W'($urandom_range(20, 60));
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd3;
            3:       return 16'd255;
            default: return CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_timings(input logic [CFG_DATA_W-1:0] all_red, green, yellow,
                                input logic [CFG_DATA_W-1:0] amb_red, amb_green, bus_hold,
                                input logic [CFG_DATA_W-1:0] thresh, rounds);
        write_reg(CFG_ALL_RED, all_red);
        write_reg(CFG_GREEN, green);
        write_reg(CFG_YELLOW, yellow);
        write_reg(CFG_AMB_RED, amb_red);
        write_reg(CFG_AMB_GREEN, amb_green);
        write_reg(CFG_BUS_HOLD, bus_hold);
        write_reg(CFG_THRESHOLD, thresh);
        write_reg(CFG_ROUND, rounds);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic [NUM_LANES-1:0] sensors, input logic amb,
                             input logic bus);
        int gap;
        gap = (source_idling && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid             <= 1'b1;
        tick_if.lane_sensors      <= sensors;
        tick_if.ambulance_request <= amb;
        tick_if.bus_request       <= bus;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
    endtask

    // sender stops until every light word has come back
    task automatic wait_for_lights();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    // light sink with random stalls and one long hold-off on request
    initial begin
        light_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                light_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idling && $urandom_range(0, 3) == 0) begin
                light_if.ready <= 1'b0;
                repeat (idle_length()) @(posedge clk);
            end
            light_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (tick_if.valid && tick_if.ready)
                || (light_if.valid && light_if.ready)) begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        tick_if.valid             <= 1'b0;
        tick_if.lane_sensors      <= '0;
        tick_if.ambulance_request <= 1'b0;
        tick_if.bus_request       <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero and one lengths, zero threshold and zero round
        load_timings(16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
        foreach (DIRECTED_TICKS[i])
            send_tick(DIRECTED_TICKS[i][5:2], DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
        wait_for_lights();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            load_timings(random_ticks(), random_ticks(), random_ticks(), random_ticks(),
                         random_ticks(), random_ticks(), random_threshold(),
                         CFG_DATA_W'($urandom_range(0, 7)));
            source_idling = (seg % 3 != 1) && (seg != 2);
            sink_idling   = (seg % 3 != 2);
            for (int n = 0; n < SEGMENT_WORDS; n++) begin
                if (seg == 2 && n == 40)
                    sink_hold_req = 1'b1;
                send_tick(NUM_LANES'($urandom_range(0, 15)), $urandom_range(0, 11) == 0,
                          1'($urandom_range(0, 1)));
            end
            wait_for_lights();
        end

        // longest phases, highest threshold and round
        load_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'd255, 16'd7);
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        for (int n = 0; n < EXTREME_WORDS; n++)
            send_tick(NUM_LANES'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        wait_for_lights();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* adaptive_traffic_light_controller.f */
+incdir+rtl
rtl/atlc_pkg.sv
rtl/atlc_intf.sv
rtl/atlc_next_lane.sv
rtl/adaptive_traffic_light_controller.sv
tb/adaptive_traffic_light_controller_checker.sv
tb/adaptive_traffic_light_controller_test.sv
